### src/rls_pkg.sv
`timescale 1ns / 1ps
package rls_pkg;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [65:0] wide_t;

  typedef enum logic [1:0] {
    KIND_LOAD_ROW = 2'd0,
    KIND_SET_EST  = 2'd1,
    KIND_NEIGHBOR = 2'd2,
    KIND_UNUSED   = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] CFG_LIN_X = 2'd0;
  localparam logic [1:0] CFG_LIN_Y = 2'd1;
  localparam logic [1:0] CFG_LIN_Z = 2'd2;

  localparam logic [1:0] LAST_ROW = 2'd2;

  localparam wide_t W_MAX = 66'sd2147483647;
  localparam wide_t W_MIN = -66'sd2147483648;

  // Clamp a wide intermediate to the signed 32-bit range.
  function automatic q32_t sat32(input wide_t v);
    q32_t res;
    if (v > W_MAX) res = 32'sh7fffffff;
    else if (v < W_MIN) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic ovf32(input wide_t v);
    return (v > W_MAX) || (v < W_MIN);
  endfunction

endpackage

### src/rls_in_if.sv
`timescale 1ns / 1ps
interface rls_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         row;
  rls_pkg::q32_t      val_a;
  rls_pkg::q32_t      val_b;
  rls_pkg::q32_t      val_c;

  modport source(output valid, kind, row, val_a, val_b, val_c, input ready);
  modport sink(input valid, kind, row, val_a, val_b, val_c, output ready);
endinterface

### src/rls_out_if.sv
`timescale 1ns / 1ps
interface rls_out_if;
  logic               valid;
  logic               ready;
  rls_pkg::q32_t      est_x;
  rls_pkg::q32_t      est_y;
  rls_pkg::q32_t      est_z;
  logic [1:0]         status;

  modport source(output valid, est_x, est_y, est_z, status, input ready);
  modport sink(input valid, est_x, est_y, est_z, status, output ready);
endinterface

### src/rls_position_refine_3d.sv
`timescale 1ns / 1ps
// Recursive least-squares refinement of a 3-D position estimate in signed
// fixed point with FRAC_BITS fraction bits.
// The in_ch channel takes one item per operation: a covariance row load, an
// estimate load or a neighbor update. Every item gives exactly one item on
// out_ch with the estimate as it stands afterwards and a status code.
// The cfg port writes the linearization point, and a write takes effect at
// once. It must be written only while the block is idle; the block itself
// does not enforce this. A neighbor update runs through one shared 32x32
// multiplier, a one-bit-per-cycle divider and a two-bits-per-cycle square
// root. The nine restoring divisions take most of the time of an update.
// The block takes one item at a time; in_ch.ready is high only while the
// sequencer is idle. The result sits in an output register, so a stalled
// receiver holds only that result, and a new item can be taken while it
// waits; the following result waits until the first one is taken.
// Reset clears the covariance matrix, the estimate and the linearization
// point to zero and leaves no result pending.
module rls_position_refine_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_idx,
  input  rls_pkg::q32_t  cfg_wdata,
  rls_in_if.sink         in_ch,
  rls_out_if.source      out_ch
);
  import rls_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_U    = 12'b000000000010,
    S_WU   = 12'b000000000100,
    S_QM   = 12'b000000001000,
    S_QD   = 12'b000000010000,
    S_PW   = 12'b000000100000,
    S_DF   = 12'b000001000000,
    S_SQ   = 12'b000010000000,
    S_G    = 12'b000100000000,
    S_WX   = 12'b001000000000,
    S_EST  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  localparam wide_t ONE = wide_t'(1) <<< FRAC_BITS;

  state_t       state_r, state_nxt;
  q32_t         lin_r  [3];
  q32_t         p_r    [9];
  q32_t         est_r  [3];
  q32_t         w_r    [3];
  q32_t         u_r    [3];
  q32_t         gain_r [3];
  q32_t         den_r, d_r, r_r;
  wide_t        acc_r;
  logic [1:0]   ci_r, cj_r;
  logic [5:0]   cnt_r;
  logic [63:0]  shift_r;
  logic [31:0]  rem_r, dmag_r, root_r;
  logic [33:0]  sq_rem_r;
  logic         neg_r, sat_r;
  logic [1:0]   status_r;
  logic         out_valid_r;
  q32_t         out_x_r, out_y_r, out_z_r;
  logic [1:0]   out_st_r;

  logic         in_acc, last_j, last_i, out_load;
  logic [3:0]   idx;
  q32_t         p_sel, df, mul_a, mul_b, wu, q_sat, dot_sat;
  logic signed [63:0] prod, qterm;
  wide_t        acc_sum, den_full, qs, pdiff, r_full, est_full, d_full;
  logic [63:0]  pmag;
  logic [32:0]  rem_sh;
  logic         div_ge, sq_ge;
  logic [35:0]  sq_sh, trial;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign last_j      = (cj_r == LAST_ROW);
  assign last_i      = (ci_r == LAST_ROW);
  assign idx         = {1'b0, ci_r, 1'b0} + {2'b00, ci_r} + {2'b00, cj_r};
  assign p_sel       = p_r[idx];
  assign df          = sat32(wide_t'(w_r[cj_r]) - wide_t'(lin_r[cj_r]));
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = p_sel;
    mul_b = w_r[cj_r];
    case (state_r)
      S_WU:    begin mul_a = w_r[cj_r]; mul_b = u_r[cj_r]; end
      S_QM:    begin mul_a = u_r[ci_r]; mul_b = u_r[cj_r]; end
      S_DF:    begin mul_a = df;        mul_b = df;        end
      S_WX:    begin mul_a = w_r[cj_r]; mul_b = est_r[cj_r]; end
      S_EST:   begin mul_a = r_r;       mul_b = gain_r[cj_r]; end
      default: begin mul_a = p_sel;     mul_b = w_r[cj_r]; end
    endcase
  end

  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign qterm    = prod >>> FRAC_BITS;
  assign acc_sum  = acc_r + wide_t'(qterm);
  assign dot_sat  = sat32(acc_sum);
  assign wu       = dot_sat;
  assign den_full = ONE + wide_t'(wu);
  assign pmag     = prod[63] ? 64'(-prod) : 64'(prod);

  assign rem_sh   = {rem_r, shift_r[63]};
  assign div_ge   = rem_sh >= {1'b0, dmag_r};
  assign qs       = neg_r ? -$signed({2'b00, shift_r}) : $signed({2'b00, shift_r});
  assign q_sat    = sat32(qs);
  assign pdiff    = wide_t'(p_sel) - wide_t'(q_sat);

  assign sq_sh    = {sq_rem_r, shift_r[63:62]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_sh >= trial;
  assign d_full   = $signed({34'd0, root_r[30:0], sq_ge});

  assign r_full   = wide_t'(d_r) - wide_t'(dot_sat);
  assign est_full = wide_t'(est_r[cj_r]) + wide_t'(qterm);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_ch.kind == KIND_NEIGHBOR) ? S_U : S_OUT;
      end
      S_U:   if (last_i && last_j) state_nxt = S_WU;
      S_WU: begin
        if (last_j) state_nxt = (sat32(den_full) == '0) ? S_OUT : S_QM;
      end
      S_QM:  state_nxt = S_QD;
      S_QD:  if (cnt_r == 6'd63) state_nxt = S_PW;
      S_PW:  state_nxt = (last_i && last_j) ? S_DF : S_QM;
      S_DF:  if (last_j) state_nxt = S_SQ;
      S_SQ:  if (cnt_r == 6'd31) state_nxt = S_G;
      S_G:   if (last_i && last_j) state_nxt = S_WX;
      S_WX:  if (last_j) state_nxt = S_EST;
      S_EST: if (last_j) state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and architectural state, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ci_r        <= '0;
      cj_r        <= '0;
      cnt_r       <= '0;
      for (int k = 0; k < 3; k++) begin
        lin_r[k] <= '0;
        est_r[k] <= '0;
      end
      for (int k = 0; k < 9; k++) p_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_idx)
          CFG_LIN_X: lin_r[0] <= cfg_wdata;
          CFG_LIN_Y: lin_r[1] <= cfg_wdata;
          CFG_LIN_Z: lin_r[2] <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          ci_r <= '0;
          cj_r <= '0;
          if (in_acc) begin
            if (in_ch.kind == KIND_LOAD_ROW && in_ch.row <= LAST_ROW) begin
              p_r[4'(in_ch.row) * 4'd3]        <= in_ch.val_a;
              p_r[4'(in_ch.row) * 4'd3 + 4'd1] <= in_ch.val_b;
              p_r[4'(in_ch.row) * 4'd3 + 4'd2] <= in_ch.val_c;
            end
            if (in_ch.kind == KIND_SET_EST) begin
              est_r[0] <= in_ch.val_a;
              est_r[1] <= in_ch.val_b;
              est_r[2] <= in_ch.val_c;
            end
          end
        end
        S_U, S_G, S_PW: begin
          if (state_r == S_PW) p_r[idx] <= sat32(pdiff);
          cj_r <= last_j ? 2'd0 : cj_r + 2'd1;
          if (last_j) ci_r <= last_i ? 2'd0 : ci_r + 2'd1;
        end
        S_WU, S_DF, S_WX: cj_r <= last_j ? 2'd0 : cj_r + 2'd1;
        S_QM: cnt_r <= '0;
        S_QD: cnt_r <= cnt_r + 6'd1;
        S_SQ: cnt_r <= cnt_r + 6'd1;
        S_EST: begin
          est_r[cj_r] <= sat32(est_full);
          cj_r <= last_j ? 2'd0 : cj_r + 2'd1;
        end
        default: ;
      endcase
      if (state_r == S_DF && last_j) cnt_r <= '0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        acc_r    <= '0;
        sat_r    <= 1'b0;
        status_r <= ST_OK;
        w_r[0]   <= in_ch.val_a;
        w_r[1]   <= in_ch.val_b;
        w_r[2]   <= in_ch.val_c;
      end
      S_U, S_G: begin
        if (last_j) begin
          if (state_r == S_U) u_r[ci_r] <= dot_sat;
          else gain_r[ci_r] <= dot_sat;
          sat_r <= sat_r | ovf32(acc_sum);
          acc_r <= '0;
        end else begin
          acc_r <= acc_sum;
        end
      end
      S_WU: begin
        if (last_j) begin
          den_r <= sat32(den_full);
          sat_r <= sat_r | ovf32(acc_sum) | ovf32(den_full);
          acc_r <= '0;
          if (sat32(den_full) == '0) status_r <= ST_ZERO;
        end else begin
          acc_r <= acc_sum;
        end
      end
      S_QM: begin
        shift_r <= pmag;
        neg_r   <= prod[63] ^ den_r[31];
        dmag_r  <= den_r[31] ? 32'(-den_r) : 32'(den_r);
        rem_r   <= '0;
      end
      S_QD: begin
        rem_r   <= div_ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
        shift_r <= {shift_r[62:0], div_ge};
      end
      S_PW: sat_r <= sat_r | ovf32(qs) | ovf32(pdiff);
      S_DF: begin
        sat_r <= sat_r | ovf32(wide_t'(w_r[cj_r]) - wide_t'(lin_r[cj_r]));
        if (last_j) begin
          shift_r  <= 64'(acc_r + wide_t'(prod));
          acc_r    <= '0;
          sq_rem_r <= '0;
          root_r   <= '0;
        end else begin
          acc_r <= acc_r + wide_t'(prod);
        end
      end
      S_SQ: begin
        sq_rem_r <= sq_ge ? 34'(sq_sh - trial) : sq_sh[33:0];
        root_r   <= {root_r[30:0], sq_ge};
        shift_r  <= {shift_r[61:0], 2'b00};
        if (cnt_r == 6'd31) begin
          d_r   <= sat32(d_full);
          sat_r <= sat_r | ovf32(d_full);
        end
      end
      S_WX: begin
        if (last_j) begin
          r_r   <= sat32(r_full);
          sat_r <= sat_r | ovf32(acc_sum) | ovf32(r_full);
        end else begin
          acc_r <= acc_sum;
        end
      end
      S_EST: begin
        sat_r <= sat_r | ovf32(est_full);
        if (last_j) status_r <= (sat_r | ovf32(est_full)) ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
    if (out_load) begin
      out_x_r  <= est_r[0];
      out_y_r  <= est_r[1];
      out_z_r  <= est_r[2];
      out_st_r <= status_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.est_x  = out_x_r;
  assign out_ch.est_y  = out_y_r;
  assign out_ch.est_z  = out_z_r;
  assign out_ch.status = out_st_r;

  // The sequencer is always in exactly one state.
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state is not one-hot");

  // An accepted item always starts work before the next one can be taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not leave idle");

  // Every division starts from a fresh step count.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QM |=> state_r == S_QD && cnt_r == 6'd0)
    else $error("division did not start cleanly");

  // A division never runs with a zero denominator.
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QD |-> den_r != '0)
    else $error("division by zero denominator");

endmodule
